// ===== rtl/ems_pkg.sv =====
// Shared types and constants of the encoder motion sequencer.
`default_nettype none

package ems_pkg;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStallLimit   = 3'd0,
    CfgTurnTarget   = 3'd1,
    CfgObstacleCm   = 3'd2,
    CfgLinearDefCm  = 3'd3,
    CfgCircleDefCm  = 3'd4
  } ems_cfg_idx_e;

  typedef struct packed {
    logic [9:0]  stall_limit;
    logic [15:0] turn_target_ticks;
    logic [7:0]  obstacle_limit_cm;
    logic [15:0] linear_default_cm;
    logic [15:0] circle_default_cm;
  } ems_cfg_t;

  // Command letters
  localparam logic [7:0] CmdStop    = 8'h53;  // S
  localparam logic [7:0] CmdForward = 8'h46;  // F
  localparam logic [7:0] CmdBack    = 8'h42;  // B
  localparam logic [7:0] CmdCircle  = 8'h43;  // C
  localparam logic [7:0] CmdRoam    = 8'h41;  // A
  localparam logic [7:0] CmdLeft    = 8'h4C;  // L
  localparam logic [7:0] CmdRight   = 8'h52;  // R

  typedef enum logic [1:0] {
    ModeLinear = 2'd0,
    ModeTurn   = 2'd1,
    ModeRoam   = 2'd2,
    ModeCircle = 2'd3
  } ems_mode_e;

  typedef enum logic [1:0] {
    EvNone = 2'd0,
    EvAck  = 2'd1,
    EvDone = 2'd2
  } ems_event_e;

  // Duty percentages
  localparam logic [6:0] DutyStraight = 7'd40;
  localparam logic [6:0] DutyCircleL  = 7'd20;
  localparam logic [6:0] DutyCircleR  = 7'd50;
  localparam logic [6:0] DutyRoam     = 7'd35;
  localparam logic [6:0] DutySpin     = 7'd45;

  // Distance to encoder ticks: cm * 14200 / 2073 as one multiply by a
  // rounded-up reciprocal; the shift keeps the error below 1/2073 for 16-bit cm.
  localparam int unsigned TickShift = 30;
  localparam int unsigned TickRecipW = 34;
  localparam logic [TickRecipW-1:0] TickRecip =
    TickRecipW'(((64'd14200 << TickShift) + 64'd2072) / 64'd2073);
  localparam int unsigned TargetW = 20;

  localparam logic [10:0] StallMax = 11'd2047;

  typedef struct packed {
    logic       en;
    logic       lrev;
    logic [6:0] lduty;
    logic       rrev;
    logic [6:0] rduty;
  } ems_drive_t;

  typedef struct packed {
    ems_drive_t drive;
    ems_event_e event_code;
    logic       obstacle_spin;
    logic       busy;
  } ems_result_t;

endpackage

`default_nettype wire

// ===== rtl/ems_if.sv =====
// Request and result channel interfaces of the encoder motion sequencer.
`default_nettype none

interface ems_in_if #(
  parameter int unsigned ENC_BITS = 32
) ();
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [7:0]                 command_char;
  logic [15:0]                distance_cm;
  logic signed [ENC_BITS-1:0] left_count;
  logic signed [ENC_BITS-1:0] right_count;
  logic [15:0]                range_cm;

  modport source (
    output valid, func, command_char, distance_cm, left_count, right_count, range_cm,
    input  ready
  );
  modport sink (
    input  valid, func, command_char, distance_cm, left_count, right_count, range_cm,
    output ready
  );
endinterface

interface ems_out_if ();
  logic       valid;
  logic       ready;
  logic       motors_enabled;
  logic       left_reverse;
  logic [6:0] left_duty;
  logic       right_reverse;
  logic [6:0] right_duty;
  logic [1:0] event_code;
  logic       obstacle_spin;
  logic       busy_res;

  modport source (
    output valid, motors_enabled, left_reverse, left_duty, right_reverse, right_duty,
           event_code, obstacle_spin, busy_res,
    input  ready
  );
  modport sink (
    input  valid, motors_enabled, left_reverse, left_duty, right_reverse, right_duty,
           event_code, obstacle_spin, busy_res,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/encoder_motion_sequencer_unit.sv =====
// Top level of the encoder motion sequencer.
// Takes one request per clock cycle while the result side accepts results, and
// returns one result per request: a request first lands in an input register,
// then one pass of logic (command decode, the distance-to-ticks multiply, encoder
// progress and stall tracking) updates the motion state and fills the result
// register. The result register and the input register are separate, so a new
// request is taken while a result still waits; the multiply of the distance by
// the tick reciprocal sets the longest path. Configuration writes take effect
// on the next cycle and belong in idle periods.
`default_nettype none

module encoder_motion_sequencer_unit #(
  parameter int unsigned ENC_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ems_in_if.sink                        in_i,
  ems_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [ems_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ems_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import ems_pkg::*;

  localparam int unsigned CmpW = (ENC_BITS > TargetW) ? ENC_BITS : TargetW;

  ems_cfg_t cfg;

  // Input register
  logic                s1_valid_q;
  logic                s1_func_q;
  logic [7:0]          s1_cmd_q;
  logic [15:0]         s1_dist_q;
  logic [ENC_BITS-1:0] s1_left_q;
  logic [ENC_BITS-1:0] s1_right_q;
  logic [15:0]         s1_range_q;

  // Motion state
  logic                active_q, active_d;
  ems_mode_e           mode_q, mode_d;
  logic [ENC_BITS-1:0] start_left_q, start_left_d;
  logic [ENC_BITS-1:0] start_right_q, start_right_d;
  logic [TargetW-1:0]  target_q, target_d;
  logic [10:0]         stall_q, stall_d;
  logic [ENC_BITS-1:0] prev_prog_q, prev_prog_d;
  ems_drive_t          drive_q, drive_d;

  // Result register
  logic        out_valid_q;
  ems_result_t res_q, res_d;

  logic                advance;
  logic [TargetW-1:0]  dist_target;
  logic [ENC_BITS-1:0] progress;
  logic                known;

  ems_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  ems_target u_target (
    .distance_cm_i(s1_dist_q),
    .circle_i     (s1_cmd_q == CmdCircle),
    .cfg_i        (cfg),
    .target_o     (dist_target)
  );

  ems_progress #(.ENC_BITS(ENC_BITS)) u_progress (
    .left_i       (s1_left_q),
    .right_i      (s1_right_q),
    .start_left_i (start_left_q),
    .start_right_i(start_right_q),
    .progress_o   (progress)
  );

  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;

  always_comb begin
    active_d      = active_q;
    mode_d        = mode_q;
    start_left_d  = start_left_q;
    start_right_d = start_right_q;
    target_d      = target_q;
    stall_d       = stall_q;
    prev_prog_d   = prev_prog_q;
    drive_d       = drive_q;
    known         = 1'b0;
    res_d         = '0;
    res_d.event_code = EvNone;

    if (!s1_func_q) begin
      if (s1_cmd_q == CmdStop) begin
        drive_d  = '0;
        active_d = 1'b0;
      end else if (!active_q) begin
        known = 1'b1;
        unique case (s1_cmd_q)
          CmdForward, CmdBack: begin
            mode_d   = ModeLinear;
            target_d = dist_target;
            drive_d  = '{en: 1'b1, lrev: (s1_cmd_q == CmdBack), lduty: DutyStraight,
                         rrev: (s1_cmd_q == CmdBack), rduty: DutyStraight};
          end
          CmdCircle: begin
            mode_d   = ModeCircle;
            target_d = dist_target;
            drive_d  = '{en: 1'b1, lrev: 1'b0, lduty: DutyCircleL,
                         rrev: 1'b0, rduty: DutyCircleR};
          end
          CmdRoam: begin
            mode_d   = ModeRoam;
            target_d = '0;
            drive_d  = '{en: 1'b1, lrev: 1'b0, lduty: DutyRoam,
                         rrev: 1'b0, rduty: DutyRoam};
          end
          CmdLeft, CmdRight: begin
            mode_d   = ModeTurn;
            target_d = TargetW'(cfg.turn_target_ticks);
            drive_d  = '{en: 1'b1, lrev: (s1_cmd_q == CmdLeft), lduty: DutySpin,
                         rrev: (s1_cmd_q == CmdRight), rduty: DutySpin};
          end
          default: known = 1'b0;
        endcase
        if (known) begin
          start_left_d     = s1_left_q;
          start_right_d    = s1_right_q;
          stall_d          = '0;
          prev_prog_d      = '0;
          active_d         = 1'b1;
          res_d.event_code = EvAck;
        end
      end
    end else if (active_q) begin
      if (mode_q == ModeRoam) begin
        if ((s1_range_q != 16'd0) && (s1_range_q < {8'h00, cfg.obstacle_limit_cm})) begin
          res_d.obstacle_spin = 1'b1;
          start_left_d        = s1_left_q;
          start_right_d       = s1_right_q;
        end
        stall_d = '0;
      end else begin
        if (progress == prev_prog_q) begin
          // saturate rather than wrap
          if (stall_q < StallMax) stall_d = stall_q + 11'd1;
        end else begin
          stall_d = '0;
        end
        prev_prog_d = progress;
        if ((CmpW'(progress) >= CmpW'(target_q)) || (stall_d > {1'b0, cfg.stall_limit})) begin
          drive_d          = '0;
          active_d         = 1'b0;
          res_d.event_code = EvDone;
        end
      end
    end

    res_d.drive = drive_d;
    res_d.busy  = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      active_q      <= 1'b0;
      mode_q        <= ModeLinear;
      start_left_q  <= '0;
      start_right_q <= '0;
      target_q      <= '0;
      stall_q       <= '0;
      prev_prog_q   <= '0;
      drive_q       <= '0;
    end else begin
      if (in_i.ready) s1_valid_q <= in_i.valid;
      if (advance) begin
        out_valid_q   <= 1'b1;
        active_q      <= active_d;
        mode_q        <= mode_d;
        start_left_q  <= start_left_d;
        start_right_q <= start_right_d;
        target_q      <= target_d;
        stall_q       <= stall_d;
        prev_prog_q   <= prev_prog_d;
        drive_q       <= drive_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_func_q  <= in_i.func;
      s1_cmd_q   <= in_i.command_char;
      s1_dist_q  <= in_i.distance_cm;
      s1_left_q  <= in_i.left_count;
      s1_right_q <= in_i.right_count;
      s1_range_q <= in_i.range_cm;
    end
    if (advance) res_q <= res_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.motors_enabled = res_q.drive.en;
  assign out_o.left_reverse   = res_q.drive.lrev;
  assign out_o.left_duty      = res_q.drive.lduty;
  assign out_o.right_reverse  = res_q.drive.rrev;
  assign out_o.right_duty     = res_q.drive.rduty;
  assign out_o.event_code     = res_q.event_code;
  assign out_o.obstacle_spin  = res_q.obstacle_spin;
  assign out_o.busy_res       = res_q.busy;

endmodule

`default_nettype wire

// ===== rtl/ems_cfg_regs.sv =====
// Configuration register file of the encoder motion sequencer.
`default_nettype none

module ems_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ems_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ems_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output ems_pkg::ems_cfg_t             cfg_o
);
  import ems_pkg::*;

  ems_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgStallLimit:  cfg_d.stall_limit       = cfg_wdata_i[9:0];
        CfgTurnTarget:  cfg_d.turn_target_ticks = cfg_wdata_i;
        CfgObstacleCm:  cfg_d.obstacle_limit_cm = cfg_wdata_i[7:0];
        CfgLinearDefCm: cfg_d.linear_default_cm = cfg_wdata_i;
        CfgCircleDefCm: cfg_d.circle_default_cm = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stall_limit       <= 10'd500;
      cfg_q.turn_target_ticks <= 16'd78;
      cfg_q.obstacle_limit_cm <= 8'd15;
      cfg_q.linear_default_cm <= 16'd5;
      cfg_q.circle_default_cm <= 16'd50;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/ems_target.sv =====
// Distance to encoder tick target conversion for straight and circle motions.
`default_nettype none

module ems_target (
  input  logic [15:0]                  distance_cm_i,
  input  logic                         circle_i,
  input  ems_pkg::ems_cfg_t            cfg_i,
  output logic [ems_pkg::TargetW-1:0]  target_o
);
  import ems_pkg::*;

  localparam int unsigned ProdW = 16 + TickRecipW;

  logic [15:0]      cm;
  logic [ProdW-1:0] prod;

  always_comb begin
    if (distance_cm_i != 16'd0) begin
      cm = distance_cm_i;
    end else if (circle_i) begin
      cm = cfg_i.circle_default_cm;
    end else begin
      cm = cfg_i.linear_default_cm;
    end
    prod = ProdW'(cm) * ProdW'(TickRecip);
  end

  assign target_o = prod[TickShift +: TargetW];

endmodule

`default_nettype wire

// ===== rtl/ems_progress.sv =====
// Mean absolute wheel movement since the latched start counts.
`default_nettype none

module ems_progress #(
  parameter int unsigned ENC_BITS = 32
) (
  input  logic [ENC_BITS-1:0] left_i,
  input  logic [ENC_BITS-1:0] right_i,
  input  logic [ENC_BITS-1:0] start_left_i,
  input  logic [ENC_BITS-1:0] start_right_i,
  output logic [ENC_BITS-1:0] progress_o
);

  logic [ENC_BITS-1:0] dl, dr, ml, mr;
  logic [ENC_BITS:0]   sum;

  always_comb begin
    // Wrapped difference read as two's complement, then its magnitude
    dl  = left_i - start_left_i;
    dr  = right_i - start_right_i;
    ml  = dl[ENC_BITS-1] ? (~dl + 1'b1) : dl;
    mr  = dr[ENC_BITS-1] ? (~dr + 1'b1) : dr;
    sum = {1'b0, ml} + {1'b0, mr};
  end

  assign progress_o = sum[ENC_BITS:1];

endmodule

`default_nettype wire

// ===== rtl/ems_checker.sv =====
// Port-level assertions for the encoder motion sequencer and their binding.
`default_nettype none

module ems_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       motors_enabled_i,
  input logic       left_reverse_i,
  input logic [6:0] left_duty_i,
  input logic       right_reverse_i,
  input logic [6:0] right_duty_i,
  input logic [1:0] event_code_i,
  input logic       obstacle_spin_i,
  input logic       busy_res_i
);
  import ems_pkg::*;

  // A motion is active exactly when the motors are driven
  a_busy_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (busy_res_i == motors_enabled_i))
    else $error("busy and motor enable disagree");

  a_off_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !motors_enabled_i) |->
      (!left_reverse_i && !right_reverse_i && left_duty_i == 7'd0 && right_duty_i == 7'd0))
    else $error("drive setting left over with motors off");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && event_code_i == EvDone) |-> !busy_res_i)
    else $error("motion done while still busy");

  a_spin_roam: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && obstacle_spin_i) |-> (busy_res_i && event_code_i == EvNone))
    else $error("obstacle spin outside an active roam tick");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result dropped while stalled");

endmodule

bind encoder_motion_sequencer_unit ems_checker u_ems_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .motors_enabled_i(out_o.motors_enabled),
  .left_reverse_i  (out_o.left_reverse),
  .left_duty_i     (out_o.left_duty),
  .right_reverse_i (out_o.right_reverse),
  .right_duty_i    (out_o.right_duty),
  .event_code_i    (out_o.event_code),
  .obstacle_spin_i (out_o.obstacle_spin),
  .busy_res_i      (out_o.busy_res)
);

`default_nettype wire
